### hdl/rpn_pkg.sv
package rpn_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int S_USER_W = 3;
    localparam int M_USER_W = 3;

    // divider produces this many quotient bits after the high-part range check
    localparam int QUOT_BITS = DATA_W + 1;

    // default configuration
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_DEPTH    = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_APPLY = 1'b1
    } action_t;

    typedef enum logic {
        WSEL_OPERAND = 1'b0,
        WSEL_ARITH   = 1'b1
    } wsel_t;

    // controller to datapath
    typedef struct packed {
        logic    load_operand;
        logic    load_b;
        logic    load_a;
        logic    mul_start;
        logic    div_start;
        logic    wr_en;
        wsel_t   wr_sel;
        op_t     op;
        logic    out_load;
        logic    out_zero;
        status_t out_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic b_zero;
        logic div_busy;
    } dp_status_t;

endpackage

### hdl/rpn_ram.sv
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/rpn_datapath.sv
module rpn_datapath #(
    parameter int STACK_DEPTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rpn_pkg::dp_cmd_t               cmd,
    input  logic [$clog2(STACK_DEPTH)-1:0] addr,
    input  logic [rpn_pkg::DATA_W-1:0]     operand_in,
    output rpn_pkg::dp_status_t            status,
    output logic [rpn_pkg::DATA_W-1:0]     result_value,
    output rpn_pkg::status_t               result_status
);

    import rpn_pkg::*;

    localparam int CNT_W = $clog2(QUOT_BITS + 1);

    // saturate a wide signed value to the 32-bit range
    function automatic logic [DATA_W-1:0] sat_wide(input logic [PROD_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){v[PROD_W-1]}}) begin
            r = v[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    logic [DATA_W-1:0]        operand_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0]        rd_data;
    logic [DATA_W-1:0]        wr_data;
    logic [DATA_W-1:0]        arith_res;
    logic [DATA_W:0]          sum_ext;
    logic [DATA_W:0]          diff_ext;
    logic [DATA_W-1:0]        add_res;
    logic [DATA_W-1:0]        sub_res;
    logic [PROD_W-1:0]        prod_shift;
    logic [DATA_W-1:0]        mul_res;
    logic [DATA_W-1:0]        div_res;
    logic [DATA_W-1:0]        out_value_reg;
    status_t                  out_status_reg;

    // divider state
    logic [DATA_W-1:0]    abs_a;
    logic [DATA_W-1:0]    abs_b;
    logic [PROD_W-1:0]    dvd_init;
    logic [PROD_W-1:0]    dvd_reg;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 div_neg_reg;
    logic                 div_ovf_reg;
    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      rem_diff;
    logic                 quot_bit;

    // value stack storage
    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // operand capture and popped values
    always_ff @(posedge aclk) begin
        if (cmd.load_operand) begin
            operand_reg <= operand_in;
        end
        if (cmd.load_b) begin
            b_reg <= rd_data;
        end
        if (cmd.load_a) begin
            a_reg <= rd_data;
        end
        if (cmd.mul_start) begin
            prod_reg <= PROD_W'(a_reg) * PROD_W'(b_reg);
        end
    end

    // saturating add and subtract
    always_comb begin
        sum_ext  = {a_reg[DATA_W-1], a_reg} + {b_reg[DATA_W-1], b_reg};
        diff_ext = {a_reg[DATA_W-1], a_reg} - {b_reg[DATA_W-1], b_reg};
        add_res  = sat_wide(PROD_W'(signed'(sum_ext)));
        sub_res  = sat_wide(PROD_W'(signed'(diff_ext)));
    end

    // product scaled back, arithmetic shift rounds toward minus infinity
    assign prod_shift = prod_reg >>> FRACTION_BITS;
    assign mul_res    = sat_wide(prod_shift);

    // divider setup: magnitudes and scaled dividend; the early range check is taken at start
    always_comb begin
        abs_a    = a_reg[DATA_W-1] ? DATA_W'(-a_reg) : DATA_W'(a_reg);
        abs_b    = b_reg[DATA_W-1] ? DATA_W'(-b_reg) : DATA_W'(b_reg);
        dvd_init = PROD_W'(abs_a) << FRACTION_BITS;
    end

    // one restoring step per cycle
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[QUOT_BITS-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        quot_bit  = (rem_shift >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            cnt_reg <= CNT_W'(QUOT_BITS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg     <= dvd_init;
            dvs_reg     <= abs_b;
            rem_reg     <= DATA_W'(dvd_init[PROD_W-1:QUOT_BITS]);
            div_ovf_reg <= (DATA_W'(dvd_init[PROD_W-1:QUOT_BITS]) >= abs_b);
            div_neg_reg <= a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
            quot_reg    <= '0;
        end else if (cnt_reg != '0) begin
            dvd_reg  <= {dvd_reg[PROD_W-2:0], 1'b0};
            rem_reg  <= quot_bit ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            quot_reg <= {quot_reg[QUOT_BITS-2:0], quot_bit};
        end
    end

    // signed, saturated quotient
    always_comb begin
        if (div_neg_reg) begin
            if (div_ovf_reg || quot_reg > {2'b01, {(DATA_W-1){1'b0}}}) begin
                div_res = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                div_res = DATA_W'(-quot_reg);
            end
        end else begin
            if (div_ovf_reg || quot_reg[QUOT_BITS-1:DATA_W-1] != '0) begin
                div_res = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                div_res = quot_reg[DATA_W-1:0];
            end
        end
    end

    // result selection and write data
    always_comb begin
        unique case (cmd.op)
            OP_ADD:  arith_res = add_res;
            OP_SUB:  arith_res = sub_res;
            OP_MUL:  arith_res = mul_res;
            OP_DIV:  arith_res = div_res;
            default: arith_res = add_res;
        endcase
        wr_data = (cmd.wr_sel == WSEL_ARITH) ? arith_res : operand_reg;
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg  <= cmd.out_zero ? '0 : rd_data;
            out_status_reg <= cmd.out_status;
        end
    end

    assign status.b_zero   = (b_reg == '0);
    assign status.div_busy = (cnt_reg != '0);
    assign result_value    = out_value_reg;
    assign result_status   = out_status_reg;

endmodule

### hdl/rpn_ctrl.sv
module rpn_ctrl #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_action,
    input  logic [1:0]                     s_op,
    input  logic                           s_last,
    output logic                           s_ready,
    output logic                           out_valid,
    input  logic                           m_ready,
    input  rpn_pkg::dp_status_t            status,
    output rpn_pkg::dp_cmd_t               cmd,
    output logic [$clog2(STACK_DEPTH)-1:0] addr
);

    import rpn_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_A,
        S_OPER,
        S_MUL,
        S_DIV_START,
        S_DIV_RUN,
        S_WRITE,
        S_FINISH,
        S_FIN_RD
    } state_t;

    state_t        state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    status_t       err_reg, err_next;
    action_t       act_reg, act_next;
    op_t           op_reg, op_next;
    logic          last_reg, last_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;
    logic          out_free;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign out_free = !out_valid_reg || m_ready;

    // sequencing of one token
    always_comb begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        act_next       = act_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = op_reg;
        addr           = '0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next         = action_t'(s_action);
                    op_next          = op_t'(s_op);
                    last_next        = s_last;
                    cmd.load_operand = 1'b1;
                    state_next       = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (err_reg != ST_OK) begin
                    state_next = S_FINISH;
                end else if (act_reg == ACT_PUSH) begin
                    if (depth_reg == DW'(STACK_DEPTH)) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WSEL_OPERAND;
                        addr       = depth_reg[AW-1:0];
                        depth_next = depth_reg + DW'(1);
                    end
                    state_next = S_FINISH;
                end else if (depth_reg < DW'(2)) begin
                    err_next   = ST_FEW;
                    state_next = S_FINISH;
                end else begin
                    addr       = depth_m1[AW-1:0];
                    state_next = S_RD_A;
                end
            end
            S_RD_A: begin
                cmd.load_b = 1'b1;
                addr       = depth_m2[AW-1:0];
                state_next = S_OPER;
            end
            S_OPER: begin
                cmd.load_a = 1'b1;
                depth_next = depth_m2;
                unique case (op_reg)
                    OP_MUL: state_next = S_MUL;
                    OP_DIV: begin
                        if (status.b_zero) begin
                            err_next   = ST_DIVZERO;
                            state_next = S_FINISH;
                        end else begin
                            state_next = S_DIV_START;
                        end
                    end
                    default: state_next = S_WRITE;
                endcase
            end
            S_MUL: begin
                cmd.mul_start = 1'b1;
                state_next    = S_WRITE;
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (!status.div_busy) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WSEL_ARITH;
                addr       = depth_reg[AW-1:0];
                depth_next = depth_reg + DW'(1);
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    priority if (err_reg != ST_OK) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_zero   = 1'b1;
                        cmd.out_status = err_reg;
                        out_valid_next = 1'b1;
                        depth_next     = '0;
                        err_next       = ST_OK;
                        state_next     = S_IDLE;
                    end else if (depth_reg != DW'(1)) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_zero   = 1'b1;
                        cmd.out_status = ST_DEPTH;
                        out_valid_next = 1'b1;
                        depth_next     = '0;
                        state_next     = S_IDLE;
                    end else begin
                        addr       = '0;
                        state_next = S_FIN_RD;
                    end
                end
            end
            S_FIN_RD: begin
                cmd.out_load   = 1'b1;
                cmd.out_zero   = 1'b0;
                cmd.out_status = ST_OK;
                out_valid_next = 1'b1;
                depth_next     = '0;
                err_next       = ST_OK;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
            act_reg       <= ACT_PUSH;
            op_reg        <= OP_ADD;
            last_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            act_reg       <= act_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hdl/rpn_stack_evaluator_unit.sv
// Reverse Polish evaluator over signed fixed-point values (Q16.16 by default).
// Input stream: one token per transfer. s_tuser[0] is the kind (push operand
// or apply operator), s_tuser[2:1] the operator, s_tdata the operand and
// s_tlast marks the final token of an expression.
// Output stream: one transfer per expression, on its final token. m_tdata is
// the value (zero on error), m_tuser[2:0] the status code.
// Timing: tokens are taken one at a time. A push passes S_DECODE and
// S_FINISH; add and subtract add S_RD_A, S_OPER and S_WRITE, multiply S_MUL,
// divide S_DIV_START and S_DIV_RUN, where it waits on the radix-2 divider,
// which resolves one of its 33 quotient bits per cycle. A valid final result
// adds S_FIN_RD for the stack read; m_tvalid rises the cycle after it.
// Reset: the stack is empty and no error is pending; the stack memory holds
// no defined contents and needs no clearing pass, as only written entries
// are read.
// Stall: the result sits in an output register, so tokens keep flowing while
// it waits; only the next final token holds until that register is taken.
module rpn_stack_evaluator_unit #(
    parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // operand_value
    input  logic [rpn_pkg::DATA_W-1:0]   s_tdata,
    // action, op_code
    input  logic [rpn_pkg::S_USER_W-1:0] s_tuser,
    input  logic                         s_tlast,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // result_value
    output logic [rpn_pkg::DATA_W-1:0]   m_tdata,
    // status
    output logic [rpn_pkg::M_USER_W-1:0] m_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready
);

    import rpn_pkg::*;

    dp_cmd_t                        cmd;
    dp_status_t                     dp_status;
    logic [$clog2(STACK_DEPTH)-1:0] addr;
    status_t                        res_status;

    // token sequencing
    rpn_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_action  (s_tuser[0]),
        .s_op      (s_tuser[2:1]),
        .s_last    (s_tlast),
        .s_ready   (s_tready),
        .out_valid (m_tvalid),
        .m_ready   (m_tready),
        .status    (dp_status),
        .cmd       (cmd),
        .addr      (addr)
    );

    // stack, arithmetic and result register
    rpn_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .addr          (addr),
        .operand_in    (s_tdata),
        .status        (dp_status),
        .result_value  (m_tdata),
        .result_status (res_status)
    );

    assign m_tuser = M_USER_W'(res_status);

endmodule

### hdl/rpn_checker.sv
module rpn_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [rpn_pkg::DATA_W-1:0]   m_tdata,
    input logic [rpn_pkg::M_USER_W-1:0] m_tuser
);

    import rpn_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != M_USER_W'(ST_OK)) |-> (m_tdata == '0))
        else $error("error result with nonzero value");

    // tokens are taken one at a time
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind rpn_stack_evaluator_unit rpn_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/rpn_stack_evaluator_unit_tb.sv
module rpn_stack_evaluator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int STACK_N      = STACK_DEPTH_DEF;
    localparam int FRAC         = FRACTION_BITS_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASE_LEN    = 180;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [DATA_W-1:0] value;
        status_t           status;
    } expr_result_t;

    // running model of the evaluator and the results it still owes
    class rpn_scoreboard;
        logic signed [DATA_W-1:0] stack_mem [STACK_N];
        int unsigned              depth = 0;
        status_t                  first_err = ST_OK;
        expr_result_t             pending_q[$];
        int unsigned              fail_count = 0;
        int unsigned              token_count = 0;
        int unsigned              expr_count = 0;
        int unsigned              status_seen[5] = '{default: 0};

        function automatic logic [DATA_W-1:0] clamp_q(longint v);
            if (v > 64'sd2147483647)
                return 32'h7fff_ffff;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return v[DATA_W-1:0];
        endfunction

        function void report_fail(string msg);
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("mismatch: %s", msg);
        endfunction

        // one accepted token on the input side
        function void note_token(action_t act, op_t op, logic [DATA_W-1:0] operand,
                                 logic last);
            longint       a;
            longint       b;
            longint       r;
            expr_result_t res;
            token_count++;
            if (first_err == ST_OK) begin
                if (act == ACT_PUSH) begin
                    if (depth >= STACK_N) begin
                        first_err = ST_OVERFLOW;
                    end else begin
                        stack_mem[depth] = operand;
                        depth++;
                    end
                end else if (depth < 2) begin
                    first_err = ST_FEW;
                end else begin
                    b = stack_mem[depth-1];
                    a = stack_mem[depth-2];
                    depth -= 2;
                    if (op == OP_DIV && b == 0) begin
                        first_err = ST_DIVZERO;
                    end else begin
                        case (op)
                            OP_ADD:  r = a + b;
                            OP_SUB:  r = a - b;
                            // arithmetic shift floors, as the datapath does
                            OP_MUL:  r = (a * b) >>> FRAC;
                            default: r = (a * (64'sd1 <<< FRAC)) / b;
                        endcase
                        stack_mem[depth] = clamp_q(r);
                        depth++;
                    end
                end
            end
            // final token closes the expression
            if (last) begin
                res.value  = '0;
                res.status = first_err;
                if (first_err == ST_OK) begin
                    if (depth == 1)
                        res.value = stack_mem[0];
                    else
                        res.status = ST_DEPTH;
                end
                pending_q.insert(pending_q.size(), res);
                status_seen[res.status]++;
                expr_count++;
                depth     = 0;
                first_err = ST_OK;
            end
        endfunction

        // one accepted transfer on the result side
        function void check_result(logic [DATA_W-1:0] data, logic [M_USER_W-1:0] user);
            expr_result_t res;
            if (pending_q.size() == 0) begin
                report_fail($sformatf("unexpected result value=%h status=%0d", data, user));
            end else begin
                res = pending_q.pop_front();
                if (data !== res.value || user !== res.status)
                    report_fail($sformatf("expected value=%h status=%0d, got value=%h status=%0d",
                                          res.value, res.status, data, user));
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [DATA_W-1:0]   s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                s_tlast  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    rpn_scoreboard board = new;
    int unsigned   items_sent = 0;
    int unsigned   src_idle_pct = 23;
    int unsigned   sink_stall_pct = 58;

    rpn_stack_evaluator_unit #(
        .STACK_DEPTH   (STACK_N),
        .FRACTION_BITS (FRAC)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    // result side: check each transfer, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // one token onto the input stream, held until the transfer
    task automatic send_token(input action_t act, input op_t op,
                              input logic [DATA_W-1:0] operand, input logic last);
        if (items_sent < PHASE_LEN) begin
            src_idle_pct   = 23;
            sink_stall_pct = 58;
        end else if (items_sent < 2 * PHASE_LEN) begin
            src_idle_pct   = 58;
            sink_stall_pct = 23;
        end else begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= operand;
        s_tuser  <= {op, act};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_token(act, op, operand, last);
        items_sent++;
    endtask

    // operands lean toward the saturation edges, zero and unity
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0001_0000;
            4:       return 32'hffff_0000;
            5, 6:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    // edge cases: overflow, ignored tokens, divide by zero, too few, bad depth
    task automatic run_directed();
        int i;
        for (i = 0; i <= STACK_N; i++)
            send_token(ACT_PUSH, op_t'(i % 4), i[0] ? 32'h8000_0000 : 32'h7fff_ffff, 1'b0);
        send_token(ACT_APPLY, OP_ADD, 32'hffff_ffff, 1'b1);
        send_token(ACT_PUSH, OP_MUL, 32'h8000_0000, 1'b0);
        send_token(ACT_PUSH, OP_SUB, 32'h0000_0000, 1'b0);
        send_token(ACT_APPLY, OP_DIV, 32'h5555_5555, 1'b0);
        send_token(ACT_APPLY, OP_SUB, 32'haaaa_aaaa, 1'b0);
        send_token(ACT_APPLY, OP_MUL, 32'h0000_0000, 1'b1);
        send_token(ACT_APPLY, OP_SUB, 32'h7fff_ffff, 1'b1);
        send_token(ACT_PUSH, OP_ADD, 32'h0001_0000, 1'b0);
        send_token(ACT_PUSH, OP_DIV, 32'hffff_ffff, 1'b1);
    endtask

    // mostly well-formed expressions, some deep ones, some random noise
    task automatic run_expression();
        int      n;
        int      i;
        int      pushes_left;
        int      live;
        bit      deep;
        action_t act;
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 20);
            for (i = 0; i < n; i++)
                send_token(action_t'($urandom_range(0, 1)), op_t'($urandom_range(0, 3)),
                           pick_operand(), i == n - 1);
        end else begin
            deep        = ($urandom_range(0, 9) == 0);
            pushes_left = deep ? $urandom_range(10, STACK_N + 1) : $urandom_range(1, 6);
            live        = 0;
            while (pushes_left > 0 || live > 1) begin
                if (live >= 2 && (pushes_left == 0 || (!deep && $urandom_range(0, 1)))) begin
                    act = ACT_APPLY;
                    live--;
                end else begin
                    act = ACT_PUSH;
                    live++;
                    pushes_left--;
                end
                send_token(act, op_t'($urandom_range(0, 3)), pick_operand(),
                           pushes_left == 0 && live == 1);
            end
        end
    endtask

    initial begin
        int unsigned directed_items;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        directed_items = items_sent;
        while (items_sent < directed_items + RANDOM_ITEMS)
            run_expression();
        s_tvalid <= 1'b0;
        // drain, then watch a while for stray results
        while (board.pending_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d tokens in %0d expressions", board.token_count,
                 board.expr_count);
        $display("outcomes: ok %0d, too few %0d, div by zero %0d, bad depth %0d, overflow %0d",
                 board.status_seen[ST_OK], board.status_seen[ST_FEW],
                 board.status_seen[ST_DIVZERO], board.status_seen[ST_DEPTH],
                 board.status_seen[ST_OVERFLOW]);
        if (board.fail_count == 0 && board.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
